>>> rtl/dnct_pkg.sv
package dnct_pkg;

	localparam int TABLE_DEPTH_C = 64;
	localparam int CODON_W       = 6;
	localparam int RES_W         = 8;

	// input item kinds (s_tuser bit 0)
	localparam logic KIND_TABLE_WR = 1'b0;
	localparam logic KIND_SEQ_BYTE = 1'b1;

	// skip value that turns translation off for the rest of a sequence
	localparam logic [1:0] SKIP_OFF = 2'd3;

	// codons found for one sequence byte, handed to the result buffer
	typedef struct packed {
		logic [1:0]         cnt;    // results for this byte, 0..2
		logic [CODON_W-1:0] idx0;
		logic [CODON_W-1:0] idx1;
		logic               rv0;    // slot 0 carries a real residue
		logic               last0;
		logic               last1;
	} dnct_cod_t;

endpackage

>>> rtl/dnct_codon_unit.sv
module dnct_codon_unit
	import dnct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       seq_acc,      // sequence byte accepted this cycle
	input  logic [7:0] packed_byte,
	input  logic [2:0] valid_bases,
	input  logic [2:0] frame,
	input  logic       first_byte,
	input  logic       seq_last,
	output dnct_cod_t  cod
);

	logic [3:0] held_q;
	logic [1:0] held_cnt_q;
	logic [1:0] skip_q;
	logic       rev_q;

	logic [3:0] held_d;
	logic [1:0] held_cnt_d;
	logic [1:0] skip_d;
	logic       rev_d;

	always_comb begin
		logic [3:0]         hb;
		logic [1:0]         hc;
		logic [1:0]         skip;
		logic               rev;
		logic [2:0]         nv;
		logic [1:0]         n;
		logic [1:0]         pos;
		logic [2:0]         sh;
		logic [1:0]         b;
		logic [CODON_W-1:0] idx;
		logic [CODON_W-1:0] i0;
		logic [CODON_W-1:0] i1;

		hb   = held_q;
		hc   = held_cnt_q;
		skip = skip_q;
		rev  = rev_q;
		n    = 2'd0;
		i0   = '0;
		i1   = '0;
		idx  = '0;
		pos  = 2'd0;
		sh   = 3'd0;
		b    = 2'd0;

		if (first_byte) begin
			hb = 4'd0;
			hc = 2'd0;
			if (frame == 3'd0 || frame == 3'd4) begin
				skip = SKIP_OFF;
				rev  = 1'b0;
			end else if (frame[2]) begin
				rev  = 1'b1;
				skip = 2'(3'd7 - frame);
			end else begin
				rev  = 1'b0;
				skip = 2'(frame - 3'd1);
			end
		end

		nv = (valid_bases > 3'd4) ? 3'd4 : valid_bases;

		// reverse strand takes the bases of a byte from the low end up
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < nv) begin
				pos = rev ? 2'(nv - 3'd1 - 3'(k)) : 2'(k);
				sh  = 3'd6 - {pos, 1'b0};
				b   = 2'(packed_byte >> sh);
				if (skip == SKIP_OFF) begin
					hb = hb;
				end else if (skip != 2'd0) begin
					skip = skip - 2'd1;
				end else if (hc == 2'd2) begin
					idx = rev ? {b, hb[1:0], hb[3:2]} : {hb[3:2], hb[1:0], b};
					hb  = 4'd0;
					hc  = 2'd0;
					if (n == 2'd0) begin
						i0 = idx;
						n  = 2'd1;
					end else if (n == 2'd1) begin
						i1 = idx;
						n  = 2'd2;
					end
				end else begin
					hb = {hb[1:0], b};
					hc = hc + 2'd1;
				end
			end
		end

		if (seq_last) begin
			hb = 4'd0;
			hc = 2'd0;
		end

		held_d     = hb;
		held_cnt_d = hc;
		skip_d     = skip;
		rev_d      = rev;

		// a closing byte with no codon still yields a bare end word
		cod.cnt   = (seq_last && n == 2'd0) ? 2'd1 : n;
		cod.idx0  = i0;
		cod.idx1  = i1;
		cod.rv0   = (n != 2'd0);
		cod.last0 = seq_last && (n != 2'd2);
		cod.last1 = seq_last && (n == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= 4'd0;
			held_cnt_q <= 2'd0;
			skip_q     <= 2'd0;
			rev_q      <= 1'b0;
		end else if (seq_acc) begin
			held_q     <= held_d;
			held_cnt_q <= held_cnt_d;
			skip_q     <= skip_d;
			rev_q      <= rev_d;
		end
	end

endmodule

>>> rtl/dnct_lookup.sv
module dnct_lookup
	import dnct_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_C
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
	input  logic [RES_W-1:0]               wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr0,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr1,
	output logic [RES_W-1:0]               rd_data0_s1,
	output logic [RES_W-1:0]               rd_data1_s1
);

	logic [RES_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data0_s1 <= mem[rd_addr0];
			rd_data1_s1 <= mem[rd_addr1];
		end
	end

endmodule

>>> rtl/dnct_out_buf.sv
module dnct_out_buf
	import dnct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,         // sequence byte accepted
	input  dnct_cod_t          cod,
	input  logic [RES_W-1:0]   rd_data0_s1,
	input  logic [RES_W-1:0]   rd_data1_s1,
	output logic               can_take,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RES_W-1:0]   out_res,
	output logic [CODON_W-1:0] out_idx,
	output logic               out_rv,
	output logic               out_last
);

	logic [1:0]         cnt_s1;
	logic               head_s1;
	logic [CODON_W-1:0] idx0_s1;
	logic [CODON_W-1:0] idx1_s1;
	logic               rv0_s1;
	logic               last0_s1;
	logic               last1_s1;

	logic               out_valid_q;
	logic [RES_W-1:0]   out_res_q;
	logic [CODON_W-1:0] out_idx_q;
	logic               out_rv_q;
	logic               out_last_q;

	logic move;

	assign move     = (cnt_s1 != 2'd0) && (!out_valid_q || out_ready);
	assign can_take = (cnt_s1 == 2'd0) || (cnt_s1 == 2'd1 && move);

	// pair stage: residues sit in the table read registers, head picks the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1  <= 2'd0;
			head_s1 <= 1'b0;
		end else if (load) begin
			cnt_s1  <= cod.cnt;
			head_s1 <= 1'b0;
		end else if (move) begin
			cnt_s1  <= cnt_s1 - 2'd1;
			head_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx0_s1  <= cod.idx0;
			idx1_s1  <= cod.idx1;
			rv0_s1   <= cod.rv0;
			last0_s1 <= cod.last0;
			last1_s1 <= cod.last1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			if (head_s1) begin
				out_res_q  <= rd_data1_s1;
				out_idx_q  <= idx1_s1;
				out_rv_q   <= 1'b1;
				out_last_q <= last1_s1;
			end else begin
				out_res_q  <= rv0_s1 ? rd_data0_s1 : '0;
				out_idx_q  <= rv0_s1 ? idx0_s1 : '0;
				out_rv_q   <= rv0_s1;
				out_last_q <= last0_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_idx   = out_idx_q;
	assign out_rv    = out_rv_q;
	assign out_last  = out_last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s1 != 2'd3)
		else $error("pair stage count out of range");

	a_head_second: assert property (@(posedge clk) disable iff (!arst_n)
		head_s1 && cnt_s1 != 2'd0 |-> cnt_s1 == 2'd1)
		else $error("second slot pending with two results left");

	a_bare_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_rv_q |-> out_last_q && out_res_q == '0 && out_idx_q == '0)
		else $error("bare end word malformed");

endmodule

>>> rtl/packed_dna_codon_translator.sv
// Packed DNA codon translator.
// s_* channel: one word per cycle while s_tready is high. s_tuser[0] = 0
// writes a translation table entry (no result); s_tuser[0] = 1 is a packed
// sequence byte with up to four 2-bit bases, first base in bits 7:6.
// s_tuser[1] opens a sequence and samples the frame; s_tlast closes it.
// m_* channel: one residue word per codon; m_tlast on the final word of a
// sequence. m_tuser = 0 marks a bare end word (frame zero or no codon),
// whose data is zero.
// Results move from the table read registers and pair stage to the output
// register. Throughput: one byte per cycle while m_tready is high and
// each byte yields at most one word; a byte with two codons holds s_tready
// low until its first word moves, as the output drains one word per cycle.
// The table is a 64-entry memory read at two addresses on byte accept.
// Reset clears the sequence state (forward, no skip, nothing held) and
// empties the result stages; table contents are undefined until written.
// When m_tready is low, results stay in the output register and pair stage,
// and s_tready drops once the pair stage cannot empty.
module packed_dna_codon_translator
	import dnct_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_C
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// table_index[5:0], table_value[13:6], packed_byte[21:14],
	// valid_bases[24:22], frame[27:25], zero fill [31:28]
	input  logic [31:0] s_tdata,
	// kind[0], first_byte[1]
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// residue[7:0], codon_index[13:8], zero fill [15:14]
	output logic [15:0] m_tdata,
	// residue_valid[0]
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic               acc;
	logic               seq_acc;
	logic               wr_acc;
	logic               can_take;
	dnct_cod_t          cod;
	logic [RES_W-1:0]   rd_data0_s1;
	logic [RES_W-1:0]   rd_data1_s1;
	logic [RES_W-1:0]   out_res;
	logic [CODON_W-1:0] out_idx;

	assign s_tready = can_take;
	assign acc      = s_tvalid && can_take;
	assign seq_acc  = acc && (s_tuser[0] == KIND_SEQ_BYTE);
	assign wr_acc   = acc && (s_tuser[0] == KIND_TABLE_WR);

	dnct_codon_unit u_codon (
		.clk         (clk),
		.arst_n      (arst_n),
		.seq_acc     (seq_acc),
		.packed_byte (s_tdata[21:14]),
		.valid_bases (s_tdata[24:22]),
		.frame       (s_tdata[27:25]),
		.first_byte  (s_tuser[1]),
		.seq_last    (s_tlast),
		.cod         (cod)
	);

	dnct_lookup #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_lookup (
		.clk         (clk),
		.wr_en       (wr_acc),
		.wr_addr     (s_tdata[AW-1:0]),
		.wr_data     (s_tdata[13:6]),
		.rd_en       (seq_acc),
		.rd_addr0    (cod.idx0[AW-1:0]),
		.rd_addr1    (cod.idx1[AW-1:0]),
		.rd_data0_s1 (rd_data0_s1),
		.rd_data1_s1 (rd_data1_s1)
	);

	dnct_out_buf u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (seq_acc),
		.cod         (cod),
		.rd_data0_s1 (rd_data0_s1),
		.rd_data1_s1 (rd_data1_s1),
		.can_take    (can_take),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (out_res),
		.out_idx     (out_idx),
		.out_rv      (m_tuser),
		.out_last    (m_tlast)
	);

	assign m_tdata = {2'b00, out_idx, out_res};

endmodule

>>> verif/tb_packed_dna_codon_translator.sv
module tb_packed_dna_codon_translator;
	timeunit 1ns;
	timeprecision 1ps;

	import dnct_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_BASES   = 4;

	localparam logic [2:0] FRAME_OFF  = 3'b000;
	localparam logic [2:0] FRAME_NONE = 3'b100;   // minus four, same as off

	typedef struct {
		logic       kind;
		logic [5:0] lut_index;
		logic [7:0] lut_value;
		logic [7:0] bases;
		logic [2:0] nvalid;
		logic [2:0] frame;
		logic       first_b;
		logic       last_b;
	} dna_word_t;

	typedef struct {
		logic [7:0] residue;
		logic [5:0] codon;
		logic       rv;
		logic       last_r;
	} residue_t;

	class residue_predictor;
		logic [7:0] codon_lut [TABLE_DEPTH_C];
		logic [3:0] held_bases;
		logic [1:0] held_count;
		logic [1:0] skip_left;
		logic       reverse;
		residue_t   residues_due [$];
		int         failures;

		function new();
			held_bases = '0;
			held_count = '0;
			skip_left  = '0;
			reverse    = 1'b0;
			failures   = 0;
		endfunction

		// returns 1 when this base closes a codon
		function bit push_base(logic [1:0] b, output logic [5:0] codon);
			codon = '0;
			if (skip_left == SKIP_OFF)
				return 1'b0;
			if (skip_left != 0) begin
				skip_left--;
				return 1'b0;
			end
			if (held_count == 2) begin
				// reverse strand: the base taken last is the first on the forward strand
				codon = reverse ? {b, held_bases[1:0], held_bases[3:2]} : {held_bases, b};
				held_bases = '0;
				held_count = '0;
				return 1'b1;
			end
			held_bases = {held_bases[1:0], b};
			held_count++;
			return 1'b0;
		endfunction

		function void absorb_word(dna_word_t w);
			int n;
			int pos;
			int found;
			logic [5:0] codon;
			found = 0;
			if (w.kind == KIND_TABLE_WR) begin
				codon_lut[w.lut_index] = w.lut_value;
				return;
			end
			if (w.first_b) begin
				held_bases = '0;
				held_count = '0;
				if (w.frame == FRAME_OFF || w.frame == FRAME_NONE) begin
					skip_left = SKIP_OFF;
					reverse   = 1'b0;
				end else if (w.frame[2]) begin
					reverse   = 1'b1;
					skip_left = 2'(7 - w.frame);
				end else begin
					reverse   = 1'b0;
					skip_left = 2'(w.frame - 1);
				end
			end
			n = (w.nvalid > MAX_BASES) ? MAX_BASES : w.nvalid;
			for (int k = 0; k < n; k++) begin
				pos = reverse ? n - 1 - k : k;
				if (push_base(w.bases[7 - 2 * pos -: 2], codon) && found < 2) begin
					residues_due.push_back('{codon_lut[codon], codon, 1'b1, 1'b0});
					found++;
				end
			end
			if (w.last_b) begin
				held_bases = '0;
				held_count = '0;
				if (found == 0)
					residues_due.push_back('{8'd0, 6'd0, 1'b0, 1'b1});
				else
					residues_due[residues_due.size() - 1].last_r = 1'b1;
			end
		endfunction

		function void check_residue(residue_t got);
			residue_t want;
			if (residues_due.size() == 0) begin
				$error("unexpected result word: residue %0d codon %0d valid %0b last %0b",
					got.residue, got.codon, got.rv, got.last_r);
				failures++;
				return;
			end
			want = residues_due.pop_front();
			if (got.residue !== want.residue) begin
				$error("residue: expected %0d, got %0d", want.residue, got.residue);
				failures++;
			end
			if (got.codon !== want.codon) begin
				$error("codon_index: expected %0d, got %0d", want.codon, got.codon);
				failures++;
			end
			if (got.rv !== want.rv) begin
				$error("residue_valid: expected %0b, got %0b", want.rv, got.rv);
				failures++;
			end
			if (got.last_r !== want.last_r) begin
				$error("last: expected %0b, got %0b", want.last_r, got.last_r);
				failures++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	residue_predictor pred = new();
	bit hold_req    = 1'b0;
	bit no_gaps     = 1'b0;
	bit offering    = 1'b0;
	int idle_cycles = 0;
	int words_sent  = 0;

	packed_dna_codon_translator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic dna_word_t seq_byte(logic [2:0] frame, logic first_b, logic last_b,
			logic [2:0] nvalid, logic [7:0] bases);
		dna_word_t w;
		w.kind      = KIND_SEQ_BYTE;
		w.lut_index = 6'($urandom);
		w.lut_value = 8'($urandom);
		w.bases     = bases;
		w.nvalid    = nvalid;
		w.frame     = frame;
		w.first_b   = first_b;
		w.last_b    = last_b;
		return w;
	endfunction

	// sequence fields are junk on a table write; the block must ignore them
	function automatic dna_word_t lut_write(logic [5:0] idx, logic [7:0] val);
		dna_word_t w;
		w = seq_byte(3'($urandom), 1'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
		w.kind      = KIND_TABLE_WR;
		w.lut_index = idx;
		w.lut_value = val;
		return w;
	endfunction

	task automatic send_word(dna_word_t w);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, w.frame, w.nvalid, w.bases, w.lut_value, w.lut_index};
		s_tuser  <= {w.first_b, w.kind};
		s_tlast  <= w.last_b;
		offering = 1'b1;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		while (pred.residues_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly well-formed sequences, some loose bytes and table rewrites
	task automatic run_random(int n_words);
		int stop;
		int r;
		int len;
		bit closed;
		logic [2:0] frame;
		logic [2:0] nv;
		stop = words_sent + n_words;
		while (words_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				send_word(seq_byte(3'($urandom), 1'($urandom), 1'($urandom), 3'($urandom),
					8'($urandom)));
			end else if (r < 12) begin
				send_word(lut_write(6'($urandom), 8'($urandom)));
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 4);
				frame = 3'($urandom_range(1, 6));
				if (frame >= 4)
					frame++;
				if ($urandom_range(0, 11) == 0)
					frame = $urandom_range(0, 1) ? FRAME_OFF : FRAME_NONE;
				closed = ($urandom_range(0, 19) != 0);
				for (int i = 0; i < len; i++) begin
					nv = (i == len - 1) ? 3'($urandom_range(1, 4)) : 3'(MAX_BASES);
					if ($urandom_range(0, 19) == 0)
						nv = 3'($urandom_range(0, 7));
					if ($urandom_range(0, 29) == 0)
						send_word(lut_write(6'($urandom), 8'($urandom)));
					send_word(seq_byte(i == 0 ? frame : 3'($urandom), i == 0,
						closed && i == len - 1, nv, 8'($urandom)));
				end
			end
		end
	endtask

	// bus monitor: feeds the predictor and checks every result word
	initial begin
		dna_word_t w;
		residue_t  r;
		forever begin
			@(posedge clk);
			if (s_tvalid && s_tready) begin
				w.lut_index = s_tdata[5:0];
				w.lut_value = s_tdata[13:6];
				w.bases     = s_tdata[21:14];
				w.nvalid    = s_tdata[24:22];
				w.frame     = s_tdata[27:25];
				w.kind      = s_tuser[0];
				w.first_b   = s_tuser[1];
				w.last_b    = s_tlast;
				pred.absorb_word(w);
			end
			if (m_tvalid && m_tready) begin
				r.residue = m_tdata[7:0];
				r.codon   = m_tdata[13:8];
				r.rv      = m_tuser;
				r.last_r  = m_tlast;
				pred.check_residue(r);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				gap = pick_gap();
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table first so no lookup hits an unwritten entry
		for (int i = 0; i < TABLE_DEPTH_C; i++)
			send_word(lut_write(6'(i), i == 0 ? 8'h00 :
				(i == TABLE_DEPTH_C - 1 ? 8'hFF : 8'($urandom))));

		// no opening byte yet: reset state reads forward with no skip
		send_word(seq_byte(3'($urandom), 1'b0, 1'b0, 3'd4, 8'hE4));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b1, 3'd4, 8'h1B));
		send_word(seq_byte(3'd1, 1'b1, 1'b1, 3'd4, 8'hFF));
		send_word(seq_byte(3'd2, 1'b1, 1'b1, 3'd4, 8'h00));
		send_word(seq_byte(3'd3, 1'b1, 1'b1, 3'd4, 8'hA5));        // too short
		send_word(seq_byte(FRAME_OFF, 1'b1, 1'b0, 3'd4, 8'h5A));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b1, 3'd4, 8'h96));
		send_word(seq_byte(FRAME_NONE, 1'b1, 1'b1, 3'd4, 8'h3C));
		// third byte of frame one closes two codons
		send_word(seq_byte(3'd1, 1'b1, 1'b0, 3'd4, 8'h39));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b0, 3'd4, 8'hC6));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b1, 3'd4, 8'h6C));
		send_word(seq_byte(3'(-1), 1'b1, 1'b0, 3'd4, 8'($urandom)));
		send_word(lut_write(6'd63, 8'hFF));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b0, 3'd4, 8'($urandom)));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b1, 3'd3, 8'($urandom)));
		send_word(seq_byte(3'(-2), 1'b1, 1'b0, 3'd4, 8'($urandom)));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b1, 3'd2, 8'($urandom)));
		send_word(seq_byte(3'(-3), 1'b1, 1'b0, 3'd4, 8'($urandom)));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b1, 3'd4, 8'($urandom)));
		// valid counts outside 1..4
		send_word(seq_byte(3'd1, 1'b1, 1'b0, 3'd0, 8'($urandom)));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b0, 3'd5, 8'($urandom)));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b0, 3'd6, 8'($urandom)));
		send_word(seq_byte(3'($urandom), 1'b0, 1'b1, 3'd7, 8'($urandom)));
		send_word(seq_byte(3'd2, 1'b1, 1'b1, 3'd0, 8'($urandom)));
		wait_drain();

		run_random(150);
		wait_drain();
		hold_req = 1'b1;   // sink stalls while words keep coming
		run_random(150);
		wait_drain();
		no_gaps = 1'b1;
		run_random(150);
		wait_drain();
		no_gaps = 1'b0;
		run_random(180);
		wait_drain();
		repeat (8) @(posedge clk);

		if (pred.residues_due.size() != 0) begin
			$error("%0d result words never arrived", pred.residues_due.size());
			pred.failures++;
		end
		if (pred.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
rtl/dnct_pkg.sv
rtl/dnct_codon_unit.sv
rtl/dnct_lookup.sv
rtl/dnct_out_buf.sv
rtl/packed_dna_codon_translator.sv
verif/tb_packed_dna_codon_translator.sv
